### rtl/pffl_pkg.sv
`timescale 1ns / 1ps

package pffl_pkg;

    // Field widths of the stream payload
    localparam int MODE_W   = 3;
    localparam int PAGE_W   = 10;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;

    // Configuration register widths
    localparam int PIU_W     = 11;
    localparam int RSV_W     = 10;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Packed stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LAST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE    = 2'd3;

    // Reset value of the managed page count
    localparam logic [PIU_W-1:0] PIU_RESET = 11'd1024;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 3'd0,
        MODE_ALLOC = 3'd1,
        MODE_FREE  = 3'd2,
        MODE_P2A   = 3'd3,
        MODE_A2P   = 3'd4
    } mode_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

endpackage

### rtl/page_frame_free_list_allocator_top.sv
`timescale 1ns / 1ps

// Page allocator over a linked free list held in one single-port page memory
// (one word per page: a free bit and the link to the next free page). Allocate,
// free and the two address translations each issue the memory read in the
// transfer cycle; the execute state then updates the entry and the head, where
// the mode changes them, and loads the result register once the output is free.
// Init takes the transfer cycle, one memory write per page, then the execute
// state that loads the result. After reset a clearing pass zeroes the free
// bits; no item is taken during it, configuration writes are. The next item
// is taken while a result still waits on the output; a result that cannot be
// placed holds the block until the output register drains.
module page_frame_free_list_allocator_top #(
    parameter int PAGES        = 1024,
    parameter int PAGE_SHIFT   = 12,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [pffl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pffl_pkg::CFG_W-1:0]      cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [9:0] page_index, [41:10] address, [42] page_in_use, [47:43] zero
    input  logic [pffl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  logic [pffl_pkg::S_TUSER_W-1:0]  s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] result_page, [41:10] result_address, [47:42] zero
    output logic [pffl_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status, [2] status_double_free
    output logic [pffl_pkg::M_TUSER_W-1:0]  m_tuser
);
    import pffl_pkg::*;

    localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;  // page memory index
    localparam int LW = $clog2(PAGES + 1);                  // link, holds empty mark
    localparam int MW = (LW > PIU_W) ? LW : PIU_W;          // compare width
    localparam int AW = ADDRESS_BITS;
    localparam int RW = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int EW = LW + 1;                             // {free, link}

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_WALK  = 4'b1000
    } state_t;

    // configuration registers
    logic [PIU_W-1:0] piu_reg;
    logic [RSV_W-1:0] rsv_first_reg;
    logic [RSV_W-1:0] rsv_last_reg;
    logic [ADDR_W-1:0] base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piu_reg       <= PIU_RESET;
            rsv_first_reg <= '0;
            rsv_last_reg  <= '0;
            base_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAGES_IN_USE:   piu_reg       <= cfg_wdata[PIU_W-1:0];
                CFG_RESERVED_FIRST: rsv_first_reg <= cfg_wdata[RSV_W-1:0];
                CFG_RESERVED_LAST:  rsv_last_reg  <= cfg_wdata[RSV_W-1:0];
                CFG_MEMORY_BASE:    base_reg      <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    state_t          state_reg, state_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]   head_reg, head_next;
    logic            out_valid_reg, out_valid_next;

    // latched item
    mode_t           mode_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic            in_use_reg;

    // result register
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                dbl_reg, dbl_next;
    logic [PAGE_W-1:0]   rpage_reg, rpage_next;
    logic [ADDR_W-1:0]   raddr_reg, raddr_next;

    // page memory ports
    logic [EW-1:0] mem [PAGES];
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // handshake
    logic in_xfer;
    logic out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // read issue at the input transfer
    assign rd_en   = in_xfer;
    assign rd_addr = (mode_t'(s_tuser[MODE_W-1:0]) == MODE_ALLOC) ? head_reg[IW-1:0]
                                                                 : IW'(s_tdata[PAGE_W-1:0]);

    // managed page count, clipped to the memory depth
    logic [MW-1:0] piu_m;
    logic [MW-1:0] managed;
    assign piu_m   = MW'(piu_reg);
    assign managed = (piu_m > MW'(PAGES)) ? MW'(PAGES) : piu_m;

    // init walk: page cnt_reg goes on the list when managed and not reserved
    logic [MW-1:0] cnt_m;
    logic          walk_take;
    logic          cnt_last;
    assign cnt_m     = MW'(cnt_reg);
    assign walk_take = (cnt_m < managed) &&
                       !(cnt_m >= MW'(rsv_first_reg) && cnt_m <= MW'(rsv_last_reg));
    assign cnt_last  = (cnt_reg == IW'(PAGES - 1));

    // item decode
    logic [MW-1:0] page_m;
    logic          head_empty;
    logic          free_reject;
    logic          rd_free;
    logic [LW-1:0] rd_link;
    assign page_m      = MW'(page_reg);
    assign head_empty  = (head_reg >= LW'(PAGES));
    assign free_reject = (page_m >= managed) || in_use_reg;
    assign rd_free     = rd_data_reg[LW];
    assign rd_link     = rd_data_reg[LW-1:0];

    // address arithmetic: one adder for page to address, one subtract back
    logic [AW-1:0] xlat_page;
    logic [AW-1:0] xlat_sum;
    logic [AW-1:0] xlat_diff;
    logic [RW-1:0] sum_wide;
    logic [RW-1:0] diff_wide;
    assign xlat_page = (mode_reg == MODE_ALLOC) ? AW'(head_reg[IW-1:0]) : AW'(page_reg);
    assign xlat_sum  = AW'(base_reg) + (xlat_page << PAGE_SHIFT);
    assign xlat_diff = AW'(addr_reg) - AW'(base_reg);
    assign sum_wide  = RW'(xlat_sum);
    assign diff_wide = RW'(xlat_diff >> PAGE_SHIFT);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        dbl_next       = dbl_reg;
        rpage_next     = rpage_reg;
        raddr_next     = raddr_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    if (mode_t'(s_tuser[MODE_W-1:0]) == MODE_INIT) begin
                        cnt_next   = '0;
                        head_next  = LW'(PAGES);
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_WALK: begin
                wr_en = 1'b1;
                if (walk_take) begin
                    wr_data   = {1'b1, head_reg};
                    head_next = LW'(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    cnt_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    dbl_next       = 1'b0;
                    rpage_next     = '0;
                    raddr_next     = '0;
                    unique case (mode_reg)
                        MODE_ALLOC: begin
                            if (head_empty) begin
                                status_next = STATUS_OOM;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = head_reg[IW-1:0];
                                wr_data    = {1'b0, rd_link};
                                head_next  = rd_link;
                                rpage_next = PAGE_W'(head_reg[IW-1:0]);
                                raddr_next = sum_wide[ADDR_W-1:0];
                            end
                        end
                        MODE_FREE: begin
                            if (free_reject) begin
                                status_next = STATUS_REFUSED;
                            end else if (rd_free) begin
                                status_next = STATUS_REFUSED;
                                dbl_next    = 1'b1;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = IW'(page_reg);
                                wr_data   = {1'b1, head_reg};
                                head_next = LW'(page_reg);
                            end
                        end
                        MODE_P2A: begin
                            rpage_next = page_reg;
                            raddr_next = sum_wide[ADDR_W-1:0];
                        end
                        MODE_A2P: begin
                            rpage_next = diff_wide[PAGE_W-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            head_reg      <= LW'(PAGES);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            mode_reg   <= mode_t'(s_tuser[MODE_W-1:0]);
            page_reg   <= s_tdata[PAGE_W-1:0];
            addr_reg   <= s_tdata[PAGE_W +: ADDR_W];
            in_use_reg <= s_tdata[PAGE_W + ADDR_W];
        end
        status_reg <= status_next;
        dbl_reg    <= dbl_next;
        rpage_reg  <= rpage_next;
        raddr_reg  <= raddr_next;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PAGE_W - ADDR_W){1'b0}}, raddr_reg, rpage_reg};
    assign m_tuser  = {dbl_reg, status_reg};

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input taken while an item is in flight");

    // head is a page index or the empty mark
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= LW'(PAGES))
        else $error("list head out of range");

    // a finished item waits while the result register is full
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) && out_valid_reg && !m_tready |=> (state_reg == ST_EXEC))
        else $error("result register overwritten");

    // a double free is always reported as a refusal
    a_dbl_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && dbl_reg |-> (status_reg == STATUS_REFUSED))
        else $error("double free flag without refusal status");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pffl_pkg::*;

    localparam int NUM_PAGES  = 1024;
    localparam int PG_SHIFT   = 12;
    localparam int PHASE_OPS  = 150;
    localparam int NUM_PHASES = 9;

    // modes with no operation behind them
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                dbl_free;
        logic [PAGE_W-1:0]   page;
        logic [ADDR_W-1:0]   addr;
    } page_reply_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // allocator mirror: configuration, head, links, free bits
    logic [PIU_W-1:0]       piu_m;
    logic [RSV_W-1:0]       rsv_first_m;
    logic [RSV_W-1:0]       rsv_last_m;
    logic [ADDR_W-1:0]      base_m;
    logic [PAGE_W:0]        head_m;
    logic [PAGE_W:0]        link_m [NUM_PAGES];
    logic                   free_m [NUM_PAGES];

    page_reply_t            replies_due[$];
    logic [PAGE_W-1:0]      held_pages[$];

    int tx_idle_pct = 28;
    int rx_idle_pct = 73;
    int errors      = 0;
    int n_checked   = 0;
    int n_init      = 0;
    int n_alloc     = 0;
    int n_free      = 0;
    int n_xlate     = 0;
    int n_spare     = 0;
    int n_oom       = 0;
    int n_refused   = 0;
    int n_dbl       = 0;

    page_frame_free_list_allocator_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [PAGE_W:0] managed_pages();
        return (piu_m > PIU_W'(NUM_PAGES)) ? PIU_W'(NUM_PAGES) : piu_m;
    endfunction

    function automatic logic [ADDR_W-1:0] page_to_addr(input logic [PAGE_W-1:0] pg);
        return base_m + ({{(ADDR_W-PAGE_W){1'b0}}, pg} << PG_SHIFT);
    endfunction

    function automatic logic [PAGE_W-1:0] rand_page();
        return PAGE_W'($urandom_range(NUM_PAGES - 1));
    endfunction

    // one allocator operation against the mirror
    function automatic page_reply_t allocator_step(input logic [MODE_W-1:0] mode,
            input logic [PAGE_W-1:0] page, input logic [ADDR_W-1:0] addr, input logic in_use);
        page_reply_t r;
        logic [PAGE_W:0] lim;
        logic [PAGE_W-1:0] pg;
        logic [ADDR_W-1:0] diff;
        int i;
        r = '0;
        lim = managed_pages();
        case (mode)
            MODE_INIT: begin
                // ascending push, highest free page lands on the head
                head_m = (PAGE_W+1)'(NUM_PAGES);
                for (i = 0; i < NUM_PAGES; i++) begin
                    free_m[i] = 1'b0;
                    if (i < lim && !(i >= rsv_first_m && i <= rsv_last_m)) begin
                        link_m[i] = head_m;
                        head_m = (PAGE_W+1)'(i);
                        free_m[i] = 1'b1;
                    end
                end
            end
            MODE_ALLOC: begin
                if (head_m[PAGE_W]) begin
                    r.status = STATUS_OOM;
                end else begin
                    pg = head_m[PAGE_W-1:0];
                    head_m = link_m[pg];
                    free_m[pg] = 1'b0;
                    r.page = pg;
                    r.addr = page_to_addr(pg);
                end
            end
            MODE_FREE: begin
                if ({1'b0, page} >= lim || in_use) begin
                    r.status = STATUS_REFUSED;
                end else if (free_m[page]) begin
                    r.status = STATUS_REFUSED;
                    r.dbl_free = 1'b1;
                end else begin
                    link_m[page] = head_m;
                    head_m = {1'b0, page};
                    free_m[page] = 1'b1;
                end
            end
            MODE_P2A: begin
                r.page = page;
                r.addr = page_to_addr(page);
            end
            MODE_A2P: begin
                diff = addr - base_m;
                r.page = PAGE_W'(diff >> PG_SHIFT);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input page_reply_t want,
            input page_reply_t got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch (%s) at %0t: want st=%0d dbl=%0d page=%0d addr=%h, got st=%0d dbl=%0d page=%0d addr=%h",
                     what, $realtime, want.status, want.dbl_free, want.page, want.addr,
                     got.status, got.dbl_free, got.page, got.addr);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        page_reply_t got;
        page_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[1:0], m_tuser[2], m_tdata[9:0], m_tdata[41:10]};
            n_checked++;
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.dbl_free !== want.dbl_free ||
                    got.page !== want.page || got.addr !== want.addr) begin
                    report_mismatch("field", want, got);
                end
            end
        end
    end

    // hold the stream until every result has drained
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input logic [PIU_W-1:0] piu, input logic [RSV_W-1:0] rf,
            input logic [RSV_W-1:0] rl, input logic [ADDR_W-1:0] base);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PAGES_IN_USE;
        cfg_wdata <= CFG_W'(piu);
        @(negedge aclk);
        cfg_index <= CFG_RESERVED_FIRST;
        cfg_wdata <= CFG_W'(rf);
        @(negedge aclk);
        cfg_index <= CFG_RESERVED_LAST;
        cfg_wdata <= CFG_W'(rl);
        @(negedge aclk);
        cfg_index <= CFG_MEMORY_BASE;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        piu_m = piu;
        rsv_first_m = rf;
        rsv_last_m = rl;
        base_m = base;
    endtask

    // send one item; the transfer updates the mirror and queues the reply
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page,
            input logic [ADDR_W-1:0] addr, input logic in_use);
        page_reply_t r;
        int k;
        @(negedge aclk);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < tx_idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'd0, in_use, addr, page};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = allocator_step(mode, page, addr, in_use);
        replies_due.push_back(r);
        // bookkeeping for stimulus choice and summary
        case (mode)
            MODE_INIT: begin
                n_init++;
                held_pages.delete();
            end
            MODE_ALLOC: begin
                n_alloc++;
                if (r.status == STATUS_OOM) n_oom++;
                else held_pages.push_back(r.page);
            end
            MODE_FREE: begin
                n_free++;
                if (r.status == STATUS_REFUSED) begin
                    n_refused++;
                    if (r.dbl_free) n_dbl++;
                end else begin
                    for (k = 0; k < held_pages.size(); k++) begin
                        if (held_pages[k] == page) begin
                            held_pages.delete(k);
                            break;
                        end
                    end
                end
            end
            MODE_P2A, MODE_A2P: n_xlate++;
            default: n_spare++;
        endcase
    endtask

    // reset state: empty list, default registers
    task automatic test_empty_after_reset();
        send_item(MODE_ALLOC, rand_page(), $urandom, 1'b0);
        send_item(MODE_FREE, 10'd1023, $urandom, 1'b0);
        send_item(MODE_ALLOC, rand_page(), $urandom, 1'b1);
        send_item(MODE_P2A, 10'd0, $urandom, 1'b0);
        send_item(MODE_A2P, rand_page(), 32'hFFFF_FFFF, 1'b0);
    endtask

    // four pages, page 1 reserved, base wraps the address space
    task automatic test_small_list();
        write_config(11'd4, 10'd1, 10'd1, 32'hFFFF_F000);
        send_item(MODE_INIT, rand_page(), $urandom, 1'b0);
        repeat (4) send_item(MODE_ALLOC, rand_page(), $urandom, 1'b0);
        send_item(MODE_FREE, 10'd2, $urandom, 1'b1);
        send_item(MODE_FREE, 10'd2, $urandom, 1'b0);
        send_item(MODE_FREE, 10'd2, $urandom, 1'b0);
        send_item(MODE_FREE, 10'd4, $urandom, 1'b0);
        send_item(MODE_FREE, 10'd1023, $urandom, 1'b0);
        send_item(MODE_FREE, 10'd1, $urandom, 1'b0);
        send_item(MODE_A2P, rand_page(), 32'h0, 1'b1);
        send_item(MODE_SPARE_FIRST, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_SPARE_LAST, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // page count above range, empty reserved range, zero pages
    task automatic test_config_extremes();
        write_config(11'd2047, 10'd10, 10'd5, 32'h1234_5000);
        send_item(MODE_INIT, rand_page(), $urandom, 1'b0);
        send_item(MODE_ALLOC, rand_page(), $urandom, 1'b0);
        send_item(MODE_P2A, 10'd1023, $urandom, 1'b1);
        write_config(11'd0, 10'd0, 10'd1023, 32'h0);
        send_item(MODE_INIT, rand_page(), $urandom, 1'b0);
        send_item(MODE_ALLOC, rand_page(), $urandom, 1'b0);
        send_item(MODE_FREE, 10'd0, $urandom, 1'b0);
    endtask

    task automatic random_phase(input int n_ops);
        logic [PIU_W-1:0] piu;
        logic [RSV_W-1:0] rf;
        logic [RSV_W-1:0] rl;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        logic [PAGE_W-1:0] pg;
        logic in_use;
        int lim;
        int sel;
        int n;
        // mostly short lists so the list runs dry and refills often
        sel = $urandom_range(9);
        if (sel < 6) piu = PIU_W'($urandom_range(48, 1));
        else if (sel == 6) piu = 11'd1;
        else if (sel == 7) piu = 11'd1024;
        else if (sel == 8) piu = PIU_W'($urandom_range(1024, 49));
        else piu = PIU_W'($urandom_range(2047, 1025));
        lim = (piu > 1024) ? 1024 : piu;
        case ($urandom_range(3))
            0: begin
                rf = RSV_W'($urandom_range(lim - 1));
                rl = rf;
            end
            1: begin
                rl = RSV_W'($urandom_range(1022));
                rf = RSV_W'($urandom_range(1023, rl + 1));
            end
            2: begin
                rf = RSV_W'($urandom_range(lim - 1));
                rl = (rf > 1019) ? 10'd1023 : rf + RSV_W'($urandom_range(4));
            end
            default: begin
                rf = rand_page();
                rl = rf;
            end
        endcase
        sel = $urandom_range(9);
        base = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
        write_config(piu, rf, rl, base);
        send_item(MODE_INIT, rand_page(), $urandom, $urandom_range(1));

        for (n = 1; n < n_ops; n++) begin
            // one pause to drain mid-phase
            if (n == n_ops / 2) wait_drained();
            pg = rand_page();
            addr = $urandom;
            in_use = $urandom_range(1);
            sel = $urandom_range(99);
            if (sel < 2) begin
                send_item(MODE_INIT, pg, addr, in_use);
            end else if (sel < 38) begin
                send_item(MODE_ALLOC, pg, addr, in_use);
            end else if (sel < 72) begin
                sel = $urandom_range(99);
                if (sel < 65 && held_pages.size() != 0) begin
                    pg = held_pages[$urandom_range(held_pages.size() - 1)];
                    in_use = 1'b0;
                end else if (sel < 75 && held_pages.size() != 0) begin
                    pg = held_pages[$urandom_range(held_pages.size() - 1)];
                    in_use = 1'b1;
                end else if (sel < 85 && !head_m[PAGE_W]) begin
                    pg = head_m[PAGE_W-1:0];
                    in_use = 1'b0;
                end
                send_item(MODE_FREE, pg, addr, in_use);
            end else if (sel < 82) begin
                send_item(MODE_P2A, pg, addr, in_use);
            end else if (sel < 95) begin
                sel = $urandom_range(9);
                if (sel < 6) addr = base_m + {rand_page(), 12'(addr)};
                else if (sel < 8) addr = base_m - ADDR_W'($urandom_range(1 << 20, 1));
                send_item(MODE_A2P, pg, addr, in_use);
            end else begin
                send_item(MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST)),
                          pg, addr, in_use);
            end
        end
    endtask

    // random phases under three idling profiles
    task automatic test_random_traffic();
        int p;
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                tx_idle_pct = 28;
                rx_idle_pct = 73;
            end else if (p < 6) begin
                tx_idle_pct = 73;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_phase(PHASE_OPS);
        end
    endtask

    initial begin
        piu_m = PIU_RESET;
        rsv_first_m = '0;
        rsv_last_m = '0;
        base_m = '0;
        head_m = (PAGE_W+1)'(NUM_PAGES);
        for (int i = 0; i < NUM_PAGES; i++) begin
            link_m[i] = '0;
            free_m[i] = 1'b0;
        end
        @(posedge aresetn);

        test_empty_after_reset();
        test_small_list();
        test_config_extremes();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge aclk);
        errors += replies_due.size();

        $display("covered %0d init, %0d allocate, %0d free, %0d translate, %0d spare-mode items",
                 n_init, n_alloc, n_free, n_xlate, n_spare);
        $display("%0d results checked: %0d out of memory, %0d frees refused (%0d double), %0d errors",
                 n_checked, n_oom, n_refused, n_dbl, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pffl_pkg.sv
rtl/page_frame_free_list_allocator_top.sv
dv/tb.sv
